/* rtl/rrw_pkg.sv */
`timescale 1ns / 1ps

package rrw_pkg;

  localparam int SEQ_W   = 32;
  localparam int TAG_W   = 32;
  localparam int LEN_W   = 16;
  localparam int ENTRY_W = SEQ_W + TAG_W + LEN_W;
  localparam int WIN_W   = 7;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_SKIP  = 2'd2,
    CMD_RESET = 2'd3
  } rrw_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_MUL,
    ST_MOD_FIX,
    ST_SCAN,
    ST_DONE
  } rrw_state_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic mod_mul;
    logic mod_fix;
    logic scan;
    logic load_out;
  } rrw_ctrl_t;

endpackage

/* rtl/rrw_ram.sv */
`timescale 1ns / 1ps

module rrw_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rrw_ctrl.sv */
`timescale 1ns / 1ps

module rrw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              req_reset,
  output rrw_pkg::rrw_ctrl_t ctrl
);

  import rrw_pkg::*;

  rrw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctrl          = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.exec = 1'b1;
          state_nxt = req_reset ? ST_MOD_MUL : ST_SCAN;
        end
      end
      ST_MOD_MUL: begin
        ctrl.mod_mul = 1'b1;
        state_nxt    = ST_MOD_FIX;
      end
      ST_MOD_FIX: begin
        ctrl.mod_fix = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          ctrl.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/rrw_datapath.sv */
`timescale 1ns / 1ps

module rrw_datapath #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rrw_pkg::rrw_ctrl_t         ctrl,
  output logic                       req_reset,
  input  logic [1:0]                 in_command,
  input  logic [rrw_pkg::SEQ_W-1:0]  in_seq,
  input  logic [rrw_pkg::TAG_W-1:0]  in_entry_tag,
  input  logic [rrw_pkg::LEN_W-1:0]  in_entry_length,
  input  logic                       cfg_wr_en,
  input  logic [rrw_pkg::WIN_W-1:0]  cfg_wr_data,
  output logic                       out_status,
  output logic [rrw_pkg::SEQ_W-1:0]  out_seq,
  output logic [rrw_pkg::TAG_W-1:0]  out_tag,
  output logic [rrw_pkg::LEN_W-1:0]  out_length,
  output logic                       out_nack_pending,
  output logic [rrw_pkg::SEQ_W-1:0]  out_nack_seq
);

  import rrw_pkg::*;

  localparam int IW        = $clog2(WINDOW_DEPTH);
  localparam int CW        = (IW + 1 > WIN_W) ? IW + 1 : WIN_W;
  localparam int FLOG      = $clog2(WINDOW_DEPTH + 1) - 1;
  localparam int MOD_SHIFT = SEQ_W + FLOG;
  // Reciprocal of the depth; the quotient estimate is at most one low.
  localparam logic [63:0] MOD_MUL_W =
    ((64'd1 << MOD_SHIFT) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [31:0] MOD_MUL = MOD_MUL_W[31:0];

  // Control state.
  logic [WIN_W-1:0]        window_size_r;
  logic [SEQ_W-1:0]        exp_r, exp_nxt;
  logic [IW-1:0]           es_r, es_nxt;
  logic [WINDOW_DEPTH-1:0] valid_r, valid_nxt;

  // Payload registers.
  logic                    status_r;
  logic                    popped_r;
  logic [63:0]             prod_r;
  logic [SEQ_W-1:0]        mod_x_r;
  logic [SEQ_W-1:0]        qd_r;
  logic [WINDOW_DEPTH-1:0] hit_r, hit_nxt;
  logic                    base_valid_r;
  logic                    out_status_r;
  logic [SEQ_W-1:0]        out_seq_r;
  logic [TAG_W-1:0]        out_tag_r;
  logic [LEN_W-1:0]        out_length_r;
  logic                    out_nack_r;
  logic [SEQ_W-1:0]        out_nack_seq_r;

  rrw_cmd_t         cmd;
  logic [WIN_W-1:0] ew;
  logic [SEQ_W-1:0] off;
  logic             in_win;
  logic             push_wrap;
  logic [IW:0]      push_sum;
  logic [IW-1:0]    push_slot;
  logic             pop_ok;
  logic             skip_match;
  logic             advance;
  logic             ram_we;
  logic             status_nxt;
  logic [ENTRY_W-1:0] rd_entry;
  logic [63:0]      q_shift;
  logic [SEQ_W-1:0] mod_val;

  assign cmd       = rrw_cmd_t'(in_command);
  assign req_reset = (cmd == CMD_RESET);

  always_comb begin
    if (32'(window_size_r) > 32'(WINDOW_DEPTH)) begin
      ew = WIN_W'(WINDOW_DEPTH);
    end else begin
      ew = window_size_r;
    end
  end

  // The window never exceeds the depth, so a pushed offset fits a slot index
  // and one subtraction folds it back. Past the 2^32 wrap the sequence itself
  // is below the depth and is its own slot.
  assign off        = in_seq - exp_r;
  assign in_win     = off < 32'(ew);
  assign push_wrap  = in_seq < exp_r;
  assign push_sum   = {1'b0, es_r} + {1'b0, off[IW-1:0]};
  assign pop_ok     = valid_r[es_r];
  assign skip_match = (in_seq == exp_r);

  always_comb begin
    if (push_wrap) begin
      push_slot = in_seq[IW-1:0];
    end else if (push_sum >= (IW + 1)'(WINDOW_DEPTH)) begin
      push_slot = IW'(push_sum - (IW + 1)'(WINDOW_DEPTH));
    end else begin
      push_slot = push_sum[IW-1:0];
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    exp_nxt    = exp_r;
    es_nxt     = es_r;
    ram_we     = 1'b0;
    advance    = 1'b0;
    status_nxt = 1'b0;
    if (ctrl.exec) begin
      unique case (cmd)
        CMD_PUSH: begin
          if (in_win) begin
            if (!valid_r[push_slot]) begin
              ram_we               = 1'b1;
              valid_nxt[push_slot] = 1'b1;
            end
          end else begin
            status_nxt = 1'b1;
          end
        end
        CMD_POP: begin
          if (pop_ok) begin
            valid_nxt[es_r] = 1'b0;
            advance         = 1'b1;
          end else begin
            status_nxt = 1'b1;
          end
        end
        CMD_SKIP: begin
          if (skip_match) begin
            valid_nxt[es_r] = 1'b0;
            advance         = 1'b1;
          end
        end
        CMD_RESET: begin
          valid_nxt = '0;
          exp_nxt   = in_seq;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
    if (advance) begin
      exp_nxt = exp_r + 32'd1;
      if ((&exp_r) || (es_r == IW'(WINDOW_DEPTH - 1))) begin
        es_nxt = '0;
      end else begin
        es_nxt = es_r + IW'(1);
      end
    end
    if (ctrl.mod_fix) begin
      es_nxt = mod_val[IW-1:0];
    end
  end

  assign q_shift = prod_r >> MOD_SHIFT;

  always_comb begin
    mod_val = mod_x_r - qd_r;
    if (mod_val >= 32'(WINDOW_DEPTH)) begin
      mod_val = mod_val - 32'(WINDOW_DEPTH);
    end
  end

  // Slot s belongs to the window beyond the expected slot when its circular
  // distance from the expected slot lies in 1..cnt_nw, or, for the part of
  // the window past the 2^32 wrap, when s is below m.
  always_comb begin
    logic [WIN_W-1:0] wm1;
    logic [WIN_W-1:0] r7;
    logic [WIN_W-1:0] cnt_nw;
    logic [WIN_W-1:0] m;
    logic [SEQ_W-1:0] r_inv;
    logic             near;
    logic [CW-1:0]    s_c;
    logic [CW-1:0]    es_c;
    logic [CW-1:0]    o;
    wm1   = ew - WIN_W'(1);
    r_inv = ~exp_r;
    near  = (r_inv[SEQ_W-1:WIN_W] == '0);
    r7    = r_inv[WIN_W-1:0];
    es_c  = CW'(es_r);
    if (ew == '0) begin
      cnt_nw = '0;
      m      = '0;
    end else if (near && (r7 < wm1)) begin
      cnt_nw = r7;
      m      = wm1 - r7;
    end else begin
      cnt_nw = wm1;
      m      = '0;
    end
    for (int s = 0; s < WINDOW_DEPTH; s++) begin
      s_c = CW'(s);
      if (s_c >= es_c) begin
        o = s_c - es_c;
      end else begin
        o = s_c + CW'(WINDOW_DEPTH) - es_c;
      end
      hit_nxt[s] = valid_r[s] &&
                   (((o != '0) && (o <= CW'(cnt_nw))) || (s_c < CW'(m)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WIN_W'(64);
      exp_r         <= '0;
      es_r          <= '0;
      valid_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        window_size_r <= cfg_wr_data;
      end
      exp_r   <= exp_nxt;
      es_r    <= es_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status_r <= status_nxt;
      popped_r <= (cmd == CMD_POP) && pop_ok;
      prod_r   <= 64'(in_seq) * 64'(MOD_MUL);
      mod_x_r  <= in_seq;
    end
    if (ctrl.mod_mul) begin
      qd_r <= 32'(q_shift[31:0] * 32'(WINDOW_DEPTH));
    end
    if (ctrl.scan) begin
      hit_r        <= hit_nxt;
      base_valid_r <= valid_r[es_r];
    end
    if (ctrl.load_out) begin
      out_status_r   <= status_r;
      out_seq_r      <= popped_r ? rd_entry[ENTRY_W-1 -: SEQ_W] : '0;
      out_tag_r      <= popped_r ? rd_entry[LEN_W +: TAG_W] : '0;
      out_length_r   <= popped_r ? rd_entry[LEN_W-1:0] : '0;
      out_nack_r     <= !base_valid_r && (|hit_r);
      out_nack_seq_r <= (!base_valid_r && (|hit_r)) ? exp_r : '0;
    end
  end

  // The read at the expected slot is taken with every accepted transaction
  // and holds until the next one, so a pop finds its entry here at the end.
  rrw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (push_slot),
    .wr_data ({in_seq, in_entry_tag, in_entry_length}),
    .rd_en   (ctrl.exec),
    .rd_addr (es_r),
    .rd_data (rd_entry)
  );

  assign out_status       = out_status_r;
  assign out_seq          = out_seq_r;
  assign out_tag          = out_tag_r;
  assign out_length       = out_length_r;
  assign out_nack_pending = out_nack_r;
  assign out_nack_seq     = out_nack_seq_r;

endmodule

/* rtl/receive_reorder_window_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_command, in_seq, in_entry_tag, in_entry_length
// out       out_valid / out_ready out_status, out_seq, out_tag, out_length,
//                                 out_nack_pending, out_nack_seq
// cfg       cfg_wr_en             cfg_wr_data (window size)
//
// Push, pop and skip pass through three steps per transaction: accept, window scan, output load.
// A window reset adds two steps, multiply and fix, for the reciprocal multiply that
// maps the new expected number to its slot.
// One transaction is in flight at a time; in_ready is high only while the
// controller is idle. A held result stalls the next one in its output load step.
// Reset clears the expected number and the valid bits and sets the window size to 64.

module receive_reorder_window_core #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic [rrw_pkg::SEQ_W-1:0] in_seq,
  input  logic [rrw_pkg::TAG_W-1:0] in_entry_tag,
  input  logic [rrw_pkg::LEN_W-1:0] in_entry_length,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_status,
  output logic [rrw_pkg::SEQ_W-1:0] out_seq,
  output logic [rrw_pkg::TAG_W-1:0] out_tag,
  output logic [rrw_pkg::LEN_W-1:0] out_length,
  output logic                      out_nack_pending,
  output logic [rrw_pkg::SEQ_W-1:0] out_nack_seq,
  input  logic                      cfg_wr_en,
  input  logic [rrw_pkg::WIN_W-1:0] cfg_wr_data
);

  import rrw_pkg::*;

  rrw_ctrl_t ctrl;
  logic      req_reset;

  rrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .req_reset (req_reset),
    .ctrl      (ctrl)
  );

  rrw_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .req_reset        (req_reset),
    .in_command       (in_command),
    .in_seq           (in_seq),
    .in_entry_tag     (in_entry_tag),
    .in_entry_length  (in_entry_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_status       (out_status),
    .out_seq          (out_seq),
    .out_tag          (out_tag),
    .out_length       (out_length),
    .out_nack_pending (out_nack_pending),
    .out_nack_seq     (out_nack_seq)
  );

endmodule
